@@ rtl/core/cct_pkg.sv @@
// ----------------------------------------------------------------------------
// cct_pkg: shared types and constants of the coulomb counting SOC tracker
// Holds the field widths, register indexes, event codes, fixed-point
// constants and the bundle of derived limits passed from the config block.
// ----------------------------------------------------------------------------
package cct_pkg;

    // Field widths
    localparam int SOC_W     = 7;
    localparam int CNT_W     = 16;
    localparam int MS_W      = 16;
    localparam int CUR_W     = 16;
    localparam int VOLT_W    = 16;
    localparam int ACC_W     = 40;
    localparam int HEALTH_W  = 7;
    localparam int CAP_W     = 8;
    localparam int CELL_MV_W = 12;
    localparam int CELLS_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    // Derived limit widths
    localparam int HC_W      = HEALTH_W + CAP_W;      // health * capacity
    localparam int ONE_PCT_W = 12;                    // up to 3238 mAh
    localparam int LIMIT_W   = 35;                    // one_pct * units per mAh
    localparam int FULL_W    = 20;                    // signed full limit
    localparam int EMPTY_W   = 18;                    // empty limit

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEALTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS    = 3'd4;

    // Register reset values
    localparam logic [HEALTH_W-1:0]  HEALTH_RST   = 7'd100;
    localparam logic [CAP_W-1:0]     CAPACITY_RST = 8'd11;
    localparam logic [CELL_MV_W-1:0] FULL_MV_RST  = 12'd3650;
    localparam logic [CELL_MV_W-1:0] EMPTY_MV_RST = 12'd2800;
    localparam logic [CELLS_W-1:0]   CELLS_RST    = 6'd15;

    // Fixed-point constants
    localparam int UNITS_PER_MAH   = 7200000;   // half mA*ms per mAh
    localparam int BAL_PER_MS      = 99;
    localparam int SELF_PER_MS     = 20;
    localparam int FULL_MARGIN_MV  = 150;
    localparam logic [VOLT_W-1:0] INVALID_TOTAL = 16'hffff;
    localparam logic [SOC_W-1:0]  SOC_FULL      = 7'd100;
    localparam logic [SOC_W-1:0]  SOC_RST       = 7'd50;
    localparam logic [CNT_W-1:0]  CYCLE_PCTS    = 16'd100;

    // Reciprocals: x/10 for x < 2^15 and x/100 for x < 2^14
    localparam int DIV10_MUL    = 26215;
    localparam int DIV10_SHIFT  = 18;
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;

    // Reset values of the derived limits
    localparam int ONE_PCT_RST = (100 * 11) / 10;
    localparam logic [HC_W-1:0]      HC_RST      = 15'd1100;
    localparam logic [ONE_PCT_W-1:0] ONE_PCT_RST_V = ONE_PCT_W'(ONE_PCT_RST);
    localparam logic [LIMIT_W-1:0]   LIMIT_RST   = LIMIT_W'(64'(ONE_PCT_RST) * UNITS_PER_MAH);
    localparam logic signed [FULL_W-1:0] FULL_LIM_RST = FULL_W'((3650 - 150) * 15);
    localparam logic [EMPTY_W-1:0]   EMPTY_LIM_RST = EMPTY_W'(2800 * 15);

    // Pack states
    localparam logic [1:0] PACK_STANDBY = 2'd0;

    // Percent event codes
    localparam logic [1:0] EVT_NONE      = 2'd0;
    localparam logic [1:0] EVT_CHARGE    = 2'd1;
    localparam logic [1:0] EVT_DISCHARGE = 2'd2;

    // Derived limits and status from the config block
    typedef struct packed {
        logic [HEALTH_W-1:0]        health;
        logic [LIMIT_W-1:0]         limit;
        logic signed [FULL_W-1:0]   full_lim;
        logic [EMPTY_W-1:0]         empty_lim;
        logic                       busy;
    } cct_limits_t;

endpackage

@@ rtl/core/cct_cfg.sv @@
// ----------------------------------------------------------------------------
// cct_cfg: configuration registers and derived limits
// Holds the five settings and recomputes the one-percent charge threshold
// and the pack voltage limits over three registered steps after a write.
// ----------------------------------------------------------------------------
module cct_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cct_pkg::CFG_DAT_W-1:0]    cfg_data,
    output cct_pkg::cct_limits_t             limits
);
    import cct_pkg::*;

    logic [HEALTH_W-1:0]       health_reg;
    logic [CAP_W-1:0]          capacity_reg;
    logic [CELL_MV_W-1:0]      full_mv_reg;
    logic [CELL_MV_W-1:0]      empty_mv_reg;
    logic [CELLS_W-1:0]        cells_reg;

    logic [HC_W-1:0]           hc_reg;
    logic [ONE_PCT_W-1:0]      one_pct_reg;
    logic [LIMIT_W-1:0]        limit_reg;
    logic signed [FULL_W-1:0]  full_lim_reg;
    logic [EMPTY_W-1:0]        empty_lim_reg;
    logic [1:0]                settle_reg;

    logic                      cfg_fire;
    logic [2*HC_W-1:0]         one_pct_prod;
    logic signed [13:0]        full_margin;
    logic signed [20:0]        full_prod;
    logic [EMPTY_W-1:0]        empty_prod;
    logic [LIMIT_W-1:0]        limit_prod;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Write the addressed register; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            health_reg   <= HEALTH_RST;
            capacity_reg <= CAPACITY_RST;
            full_mv_reg  <= FULL_MV_RST;
            empty_mv_reg <= EMPTY_MV_RST;
            cells_reg    <= CELLS_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_HEALTH:   health_reg   <= cfg_data[HEALTH_W-1:0];
                REG_CAPACITY: capacity_reg <= cfg_data[CAP_W-1:0];
                REG_FULL_MV:  full_mv_reg  <= cfg_data[CELL_MV_W-1:0];
                REG_EMPTY_MV: empty_mv_reg <= cfg_data[CELL_MV_W-1:0];
                REG_CELLS:    cells_reg    <= cfg_data[CELLS_W-1:0];
                default:      ;
            endcase
        end
    end

    // Step products: voltage limits, health times capacity, divide by ten, units per mAh
    assign full_margin  = $signed({2'b00, full_mv_reg}) - 14'sd150;
    assign full_prod    = full_margin * $signed({1'b0, cells_reg});
    assign empty_prod   = EMPTY_W'(empty_mv_reg * cells_reg);
    assign one_pct_prod = hc_reg * HC_W'(DIV10_MUL);
    assign limit_prod   = LIMIT_W'(one_pct_reg * 23'(UNITS_PER_MAH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg        <= HC_RST;
            one_pct_reg   <= ONE_PCT_RST_V;
            limit_reg     <= LIMIT_RST;
            full_lim_reg  <= FULL_LIM_RST;
            empty_lim_reg <= EMPTY_LIM_RST;
        end
        else
        begin
            hc_reg        <= health_reg * capacity_reg;
            one_pct_reg   <= one_pct_prod[DIV10_SHIFT +: ONE_PCT_W];
            limit_reg     <= limit_prod;
            full_lim_reg  <= full_prod[FULL_W-1:0];
            empty_lim_reg <= empty_prod;
        end
    end

    // Hold busy until the three derived steps have settled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= 2'd0;
        else if (cfg_fire)
            settle_reg <= 2'd3;
        else if (settle_reg != 2'd0)
            settle_reg <= settle_reg - 2'd1;
    end

    assign limits.health    = health_reg;
    assign limits.limit     = limit_reg;
    assign limits.full_lim  = full_lim_reg;
    assign limits.empty_lim = empty_lim_reg;
    assign limits.busy      = (settle_reg != 2'd0);

endmodule

@@ rtl/core/coulomb_counting_soc_tracker.sv @@
// ----------------------------------------------------------------------------
// coulomb_counting_soc_tracker: coulomb counting state-of-charge tracker
// Integrates pack current per tick word and reports SOC, percent events,
// percent counters and the cycle count.
// ----------------------------------------------------------------------------
// Usage:
//   Send one tick word on the s_ channel (elapsed time, current, pack state,
//   balancing flag and voltages). One result word per tick leaves on the m_
//   channel, in order. Settings must be written on the cfg channel while idle;
//   the block does not enforce this. Ticks pass stages A, B, C and D in turn.
//   Throughput: one tick per cycle while not stalled or busy; the state
//   update (one 17x16 multiply, a 40-bit add and the threshold compares) is
//   combinational, and the reported SOC scaling uses the two stages after it.
//   After a config write s_tready stays low while the charge threshold and
//   voltage limits are recomputed.
//   Reset clears the accumulator and counters, sets both SOC values to 50
//   and the settings to their defaults; no result is pending after reset.
//   When m_tready is low with a result waiting, the whole pipeline holds
//   and s_tready drops; items already inside are kept, none are dropped.
// ----------------------------------------------------------------------------
module coulomb_counting_soc_tracker
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cct_pkg::CFG_DAT_W-1:0]    cfg_data,
    // tick input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // elapsed_ms[15:0], current_ma[31:16], pack_voltage[47:32],
    // total_voltage[63:48]
    input  logic [63:0]                      s_tdata,
    // pack_state[1:0], balancing[2]
    input  logic [2:0]                       s_tuser,
    // result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // soc_percent[6:0], reported_soc[13:7], soc_measured[20:14],
    // charge_percents[36:21], discharge_percents[52:37], cycle_count[68:53],
    // zero[71:69]
    output logic [71:0]                      m_tdata,
    // percent_event[1:0]
    output logic [1:0]                       m_tuser
);
    import cct_pkg::*;

    cct_limits_t               limits;

    // pipeline control
    logic                      adv;
    logic                      s_fire;
    logic                      a_valid_reg;
    logic                      b_valid_reg;
    logic                      c_valid_reg;
    logic                      d_valid_reg;

    // stage A: input register
    logic [MS_W-1:0]           ms_reg;
    logic signed [CUR_W-1:0]   cur_reg;
    logic [1:0]                pstate_reg;
    logic                      bal_reg;
    logic [VOLT_W-1:0]         pack_v_reg;
    logic [VOLT_W-1:0]         total_v_reg;

    // stage B: tracker state
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [CUR_W-1:0]   prev_cur_reg;
    logic [SOC_W-1:0]          measured_reg;
    logic [SOC_W-1:0]          shown_reg;
    logic [CNT_W-1:0]          chg_cnt_reg;
    logic [CNT_W-1:0]          dis_cnt_reg;
    logic [CNT_W-1:0]          cycles_reg;
    logic [1:0]                event_reg;

    logic signed [ACC_W-1:0]   acc_next;
    logic signed [CUR_W-1:0]   prev_cur_next;
    logic [SOC_W-1:0]          measured_next;
    logic [SOC_W-1:0]          shown_next;
    logic [CNT_W-1:0]          chg_cnt_next;
    logic [CNT_W-1:0]          dis_cnt_next;
    logic [CNT_W-1:0]          cycles_next;
    logic [1:0]                event_next;

    // stage C: scaling product
    logic [SOC_W-1:0]          c_shown_reg;
    logic [SOC_W-1:0]          c_measured_reg;
    logic [CNT_W-1:0]          c_chg_reg;
    logic [CNT_W-1:0]          c_dis_reg;
    logic [CNT_W-1:0]          c_cycles_reg;
    logic [1:0]                c_event_reg;
    logic [2*SOC_W-1:0]        c_prod_reg;

    // stage D: result register
    logic [SOC_W-1:0]          d_shown_reg;
    logic [SOC_W-1:0]          d_reported_reg;
    logic [SOC_W-1:0]          d_measured_reg;
    logic [CNT_W-1:0]          d_chg_reg;
    logic [CNT_W-1:0]          d_dis_reg;
    logic [CNT_W-1:0]          d_cycles_reg;
    logic [1:0]                d_event_reg;

    // update datapath
    logic signed [CUR_W-1:0]   cur_eff;
    logic signed [CUR_W:0]     cur_sum;
    logic signed [CUR_W+MS_W+1:0] trap_prod;
    logic [6:0]                drain_rate;
    logic [MS_W+6:0]           drain;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   limit_pos;
    logic signed [ACC_W-1:0]   limit_neg;
    logic signed [FULL_W:0]    pack_v_s;
    logic                      total_ok;
    logic                      at_full;
    logic                      at_empty;
    logic [2*SOC_W+13:0]       rep_prod;

    cct_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    // Advance all stages together unless the result word is stalled
    assign adv      = !d_valid_reg || m_tready;
    assign s_tready = adv && !limits.busy;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= s_fire;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // Capture the tick word
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            ms_reg      <= s_tdata[15:0];
            cur_reg     <= s_tdata[31:16];
            pack_v_reg  <= s_tdata[47:32];
            total_v_reg <= s_tdata[63:48];
            pstate_reg  <= s_tuser[1:0];
            bal_reg     <= s_tuser[2];
        end
    end

    // Trapezoid integration, drains and threshold limits
    assign cur_eff    = (pstate_reg == PACK_STANDBY) ? '0 : cur_reg;
    assign cur_sum    = (CUR_W+1)'(cur_eff) + (CUR_W+1)'(prev_cur_reg);
    assign trap_prod  = cur_sum * $signed({1'b0, ms_reg});
    assign drain_rate = bal_reg ? 7'(BAL_PER_MS + SELF_PER_MS) : 7'(SELF_PER_MS);
    assign drain      = ms_reg * drain_rate;
    assign acc_sum    = acc_reg + ACC_W'(trap_prod) - $signed(ACC_W'(drain));
    assign limit_pos  = $signed(ACC_W'(limits.limit));
    assign limit_neg  = -limit_pos;

    // Voltage limits apply only with a valid total
    assign pack_v_s   = $signed({{(FULL_W+1-VOLT_W){1'b0}}, pack_v_reg});
    assign total_ok   = (total_v_reg != '0) && (total_v_reg != INVALID_TOTAL);
    assign at_full    = pack_v_s >= (FULL_W+1)'(limits.full_lim);
    assign at_empty   = pack_v_s <= $signed({{(FULL_W+1-EMPTY_W){1'b0}}, limits.empty_lim});

    always_comb
    begin
        acc_next      = acc_sum;
        prev_cur_next = cur_eff;
        measured_next = measured_reg;
        shown_next    = shown_reg;
        chg_cnt_next  = chg_cnt_reg;
        dis_cnt_next  = dis_cnt_reg;
        cycles_next   = cycles_reg;
        event_next    = EVT_NONE;

        // step a percent at either threshold
        if (acc_sum >= limit_pos)
        begin
            acc_next      = '0;
            chg_cnt_next  = chg_cnt_reg + 1'b1;
            event_next    = EVT_CHARGE;
            measured_next = (measured_reg >= SOC_FULL) ? SOC_FULL : measured_reg + 1'b1;
            shown_next    = measured_next;
        end
        else if (acc_sum <= limit_neg)
        begin
            acc_next      = '0;
            dis_cnt_next  = dis_cnt_reg + 1'b1;
            event_next    = EVT_DISCHARGE;
            measured_next = (measured_reg != '0) ? measured_reg - 1'b1 : measured_reg;
            shown_next    = measured_next;
        end

        // force shown SOC at a voltage limit and close a cycle once both counts reach CYCLE_PCTS
        if (total_ok && (at_full || at_empty))
        begin
            shown_next = at_full ? SOC_FULL : '0;
            if ((chg_cnt_next >= CYCLE_PCTS) && (dis_cnt_next >= CYCLE_PCTS))
            begin
                chg_cnt_next = chg_cnt_next - CYCLE_PCTS;
                dis_cnt_next = dis_cnt_next - CYCLE_PCTS;
                cycles_next  = cycles_reg + 1'b1;
            end
        end
    end

    // Update the tracker state once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            prev_cur_reg <= '0;
            measured_reg <= SOC_RST;
            shown_reg    <= SOC_RST;
            chg_cnt_reg  <= '0;
            dis_cnt_reg  <= '0;
            cycles_reg   <= '0;
            event_reg    <= EVT_NONE;
        end
        else if (adv && a_valid_reg)
        begin
            acc_reg      <= acc_next;
            prev_cur_reg <= prev_cur_next;
            measured_reg <= measured_next;
            shown_reg    <= shown_next;
            chg_cnt_reg  <= chg_cnt_next;
            dis_cnt_reg  <= dis_cnt_next;
            cycles_reg   <= cycles_next;
            event_reg    <= event_next;
        end
    end

    // Scale the shown SOC by health
    always_ff @(posedge clk)
    begin
        if (adv && b_valid_reg)
        begin
            c_shown_reg    <= shown_reg;
            c_measured_reg <= measured_reg;
            c_chg_reg      <= chg_cnt_reg;
            c_dis_reg      <= dis_cnt_reg;
            c_cycles_reg   <= cycles_reg;
            c_event_reg    <= event_reg;
            c_prod_reg     <= shown_reg * limits.health;
        end
    end

    // Divide by one hundred through the reciprocal
    assign rep_prod = c_prod_reg * 14'(DIV100_MUL);

    always_ff @(posedge clk)
    begin
        if (adv && c_valid_reg)
        begin
            d_shown_reg    <= c_shown_reg;
            d_reported_reg <= rep_prod[DIV100_SHIFT +: SOC_W];
            d_measured_reg <= c_measured_reg;
            d_chg_reg      <= c_chg_reg;
            d_dis_reg      <= c_dis_reg;
            d_cycles_reg   <= c_cycles_reg;
            d_event_reg    <= c_event_reg;
        end
    end

    assign m_tvalid = d_valid_reg;
    assign m_tdata  = {3'b000, d_cycles_reg, d_dis_reg, d_chg_reg,
                       d_measured_reg, d_reported_reg, d_shown_reg};
    assign m_tuser  = d_event_reg;

    // No tick enters while the derived limits are settling
    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        limits.busy |-> !s_tready)
        else $error("tick accepted while limits settle");

    // Coulomb counted and shown SOC stay within range
    a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (measured_reg <= SOC_FULL) && (shown_reg <= SOC_FULL))
        else $error("SOC out of range");

    // A percent event always leaves a cleared accumulator
    a_event_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && a_valid_reg && (event_next != EVT_NONE)) |=> (acc_reg == '0))
        else $error("accumulator not cleared on percent event");

    // The reported SOC never exceeds the shown SOC by more than 27
    a_reported: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13:7] <= m_tdata[6:0] + 7'd27))
        else $error("reported SOC above scaled shown SOC");

endmodule
